>>> src/fraction_reducer_macros.svh
// ----------------------------------------------------------------------------
// fraction reducer assertion macros
// concurrent assertion shorthands clocked on clk_i, disabled in reset
// ----------------------------------------------------------------------------
`ifndef FRACTION_REDUCER_MACROS_SVH
`define FRACTION_REDUCER_MACROS_SVH

// same-cycle implication
`define FR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fraction_reducer check failed");

// next-cycle implication
`define FR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fraction_reducer check failed");

`endif

>>> src/fr_pkg.sv
// ----------------------------------------------------------------------------
// fraction reducer package
// payload types, microcode word layout and sign helpers
// ----------------------------------------------------------------------------
package fr_pkg;

  localparam int DataWidth = 32;
  localparam int CntW      = $clog2(DataWidth);
  localparam int PcW       = 4;

  typedef struct packed {
    logic signed [DataWidth-1:0] numerator;
    logic signed [DataWidth-1:0] denominator;
  } in_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] reduced_numerator;
    logic signed [DataWidth-1:0] reduced_denominator;
    logic                        is_whole;
    logic signed [DataWidth-1:0] whole_value;
    logic                        error;
  } out_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_NOP,
    OP_TWOS,
    OP_GCD,
    OP_DIV_N,
    OP_DIV_STEP,
    OP_DIV_D,
    OP_FINISH,
    OP_ERROR,
    OP_ZERO
  } op_e;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_DEN_ZERO,
    C_NUM_ZERO,
    C_BOTH_EVEN,
    C_NOT_EQUAL,
    C_DIV_MORE
  } cond_e;

  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [PcW-1:0] target;
  } uword_t;

  typedef struct packed {
    logic start;
    logic den_zero;
    logic num_zero;
    logic both_even;
    logic not_equal;
    logic div_more;
  } flags_t;

  // program addresses
  localparam logic [PcW-1:0] PcIdle   = 4'd0;
  localparam logic [PcW-1:0] PcTwos   = 4'd3;
  localparam logic [PcW-1:0] PcGcd    = 4'd4;
  localparam logic [PcW-1:0] PcDivN   = 4'd6;
  localparam logic [PcW-1:0] PcDivD   = 4'd8;
  localparam logic [PcW-1:0] PcError  = 4'd10;
  localparam logic [PcW-1:0] PcZero   = 4'd11;

  function automatic logic [DataWidth-1:0] magnitude(input logic [DataWidth-1:0] v);
    return v[DataWidth-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [DataWidth-1:0] apply_sign(input logic [DataWidth-1:0] m,
                                                      input logic neg);
    return neg ? (~m + 1'b1) : m;
  endfunction

endpackage

>>> src/fr_seq.sv
// ----------------------------------------------------------------------------
// fraction reducer sequencer
// step counter over a read-only control program with conditional jumps
// ----------------------------------------------------------------------------
module fr_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fr_pkg::flags_t flags_i,
  output fr_pkg::uword_t uword_o,
  output logic           busy_o
);

  logic [fr_pkg::PcW-1:0] pc_q, pc_d;
  fr_pkg::uword_t         uw;
  logic                   take;

  function automatic fr_pkg::uword_t rom(input logic [fr_pkg::PcW-1:0] addr);
    fr_pkg::uword_t w;
    w = '{op: fr_pkg::OP_NOP, cond: fr_pkg::C_ALWAYS, target: fr_pkg::PcIdle};
    case (addr)
      4'd0:  w = '{fr_pkg::OP_IDLE,     fr_pkg::C_NO_START,  fr_pkg::PcIdle};
      4'd1:  w = '{fr_pkg::OP_NOP,      fr_pkg::C_DEN_ZERO,  fr_pkg::PcError};
      4'd2:  w = '{fr_pkg::OP_NOP,      fr_pkg::C_NUM_ZERO,  fr_pkg::PcZero};
      4'd3:  w = '{fr_pkg::OP_TWOS,     fr_pkg::C_BOTH_EVEN, fr_pkg::PcTwos};
      4'd4:  w = '{fr_pkg::OP_GCD,      fr_pkg::C_NOT_EQUAL, fr_pkg::PcGcd};
      4'd5:  w = '{fr_pkg::OP_DIV_N,    fr_pkg::C_NEVER,     fr_pkg::PcIdle};
      4'd6:  w = '{fr_pkg::OP_DIV_STEP, fr_pkg::C_DIV_MORE,  fr_pkg::PcDivN};
      4'd7:  w = '{fr_pkg::OP_DIV_D,    fr_pkg::C_NEVER,     fr_pkg::PcIdle};
      4'd8:  w = '{fr_pkg::OP_DIV_STEP, fr_pkg::C_DIV_MORE,  fr_pkg::PcDivD};
      4'd9:  w = '{fr_pkg::OP_FINISH,   fr_pkg::C_ALWAYS,    fr_pkg::PcIdle};
      4'd10: w = '{fr_pkg::OP_ERROR,    fr_pkg::C_ALWAYS,    fr_pkg::PcIdle};
      4'd11: w = '{fr_pkg::OP_ZERO,     fr_pkg::C_ALWAYS,    fr_pkg::PcIdle};
      default: w = '{fr_pkg::OP_NOP,    fr_pkg::C_ALWAYS,    fr_pkg::PcIdle};
    endcase
    return w;
  endfunction

  assign uw = rom(pc_q);

  always_comb begin
    case (uw.cond)
      fr_pkg::C_NEVER:     take = 1'b0;
      fr_pkg::C_ALWAYS:    take = 1'b1;
      fr_pkg::C_NO_START:  take = !flags_i.start;
      fr_pkg::C_DEN_ZERO:  take = flags_i.den_zero;
      fr_pkg::C_NUM_ZERO:  take = flags_i.num_zero;
      fr_pkg::C_BOTH_EVEN: take = flags_i.both_even;
      fr_pkg::C_NOT_EQUAL: take = flags_i.not_equal;
      fr_pkg::C_DIV_MORE:  take = flags_i.div_more;
      default:             take = 1'b0;
    endcase
  end

  assign pc_d = take ? uw.target : pc_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= fr_pkg::PcIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign uword_o = uw;
  assign busy_o  = (pc_q != fr_pkg::PcIdle);

endmodule

>>> src/fraction_reducer.sv
// order: a zero denominator goes from the check state to the error state, which raises done_o;
// a zero numerator passes that check and goes to the zero state; the general case runs the
// common-factor loop, the binary gcd loop and the two restoring divisions, then the finish step
// flow: one item at a time, busy high until the result strobe, next transfer taken in
// the strobe cycle; time per item depends on the operands through the common-factor and gcd loops
// reset: asynchronous active low, returns the sequencer to idle and clears done_o
// ----------------------------------------------------------------------------
// fraction reducer
// reduces a signed fraction to lowest terms with binary gcd and shift-subtract division
// ----------------------------------------------------------------------------
module fraction_reducer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  fr_pkg::in_t   operands_i,
  output logic          busy,
  output logic          done_o,
  output fr_pkg::out_t  result_o
);

  localparam int W = fr_pkg::DataWidth;

  fr_pkg::uword_t         uw;
  fr_pkg::flags_t         flags;
  logic                   seq_busy;

  logic [W-1:0]           mn_q, md_q, a_q, b_q, dv_q, q_q, r_q, rn_q;
  logic                   sn_q, sd_q;
  logic [fr_pkg::CntW-1:0] k_q, cnt_q;
  fr_pkg::out_t           res_q;
  logic                   done_q;

  logic [W-1:0]           trial;
  logic                   ge;
  logic                   rd_one;

  fr_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .uword_o (uw),
    .busy_o  (seq_busy)
  );

  assign flags.start     = start;
  assign flags.den_zero  = (md_q == '0);
  assign flags.num_zero  = (mn_q == '0);
  assign flags.both_even = !a_q[0] && !b_q[0];
  assign flags.not_equal = (a_q != b_q);
  assign flags.div_more  = (cnt_q != fr_pkg::CntW'(W - 1));

  // remainder stays below the divisor, so its top bit is free for the shift
  assign trial  = {r_q[W-2:0], q_q[W-1]};
  assign ge     = (trial >= dv_q);
  assign rd_one = (q_q == W'(1));

  always_ff @(posedge clk_i) begin
    case (uw.op)
      fr_pkg::OP_IDLE: begin
        if (start) begin
          mn_q <= fr_pkg::magnitude(operands_i.numerator);
          md_q <= fr_pkg::magnitude(operands_i.denominator);
          a_q  <= fr_pkg::magnitude(operands_i.numerator);
          b_q  <= fr_pkg::magnitude(operands_i.denominator);
          sn_q <= operands_i.numerator[W-1];
          sd_q <= operands_i.denominator[W-1];
          k_q  <= '0;
        end
      end
      fr_pkg::OP_TWOS: begin
        if (!a_q[0] && !b_q[0]) begin
          a_q <= a_q >> 1;
          b_q <= b_q >> 1;
          k_q <= k_q + 1'b1;
        end
      end
      fr_pkg::OP_GCD: begin
        if (!a_q[0]) begin
          a_q <= a_q >> 1;
        end else if (!b_q[0]) begin
          b_q <= b_q >> 1;
        end else if (a_q > b_q) begin
          a_q <= a_q - b_q;
        end else if (b_q > a_q) begin
          b_q <= b_q - a_q;
        end
      end
      fr_pkg::OP_DIV_N: begin
        dv_q  <= a_q << k_q;
        q_q   <= mn_q;
        r_q   <= '0;
        cnt_q <= '0;
      end
      fr_pkg::OP_DIV_STEP: begin
        q_q   <= {q_q[W-2:0], ge};
        r_q   <= ge ? (trial - dv_q) : trial;
        cnt_q <= cnt_q + 1'b1;
      end
      fr_pkg::OP_DIV_D: begin
        rn_q  <= q_q;
        q_q   <= md_q;
        r_q   <= '0;
        cnt_q <= '0;
      end
      fr_pkg::OP_FINISH: begin
        res_q.reduced_numerator   <= fr_pkg::apply_sign(rn_q, sn_q);
        res_q.reduced_denominator <= fr_pkg::apply_sign(q_q, sd_q);
        res_q.is_whole            <= rd_one;
        res_q.whole_value         <= rd_one ? fr_pkg::apply_sign(rn_q, sn_q ^ sd_q) : '0;
        res_q.error               <= 1'b0;
      end
      fr_pkg::OP_ERROR: begin
        res_q.reduced_numerator   <= '0;
        res_q.reduced_denominator <= '0;
        res_q.is_whole            <= 1'b0;
        res_q.whole_value         <= '0;
        res_q.error               <= 1'b1;
      end
      fr_pkg::OP_ZERO: begin
        res_q.reduced_numerator   <= '0;
        res_q.reduced_denominator <= W'(1);
        res_q.is_whole            <= 1'b1;
        res_q.whole_value         <= '0;
        res_q.error               <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (uw.op == fr_pkg::OP_FINISH) || (uw.op == fr_pkg::OP_ERROR) ||
                (uw.op == fr_pkg::OP_ZERO);
    end
  end

  assign busy     = seq_busy;
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

>>> src/fr_checker.sv
// ----------------------------------------------------------------------------
// fraction reducer port checker
// temporal checks on the command handshake and result strobe
// ----------------------------------------------------------------------------
`include "fraction_reducer_macros.svh"

module fr_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         start,
  input logic         busy,
  input logic         done_o,
  input fr_pkg::out_t result_o
);

  // a transfer starts work
  `FR_ASSERT_NEXT(a_start_busy, start && !busy, busy)

  // results arrive with the block idle and never back to back
  `FR_ASSERT_NOW(a_done_idle, done_o, !busy)
  `FR_ASSERT_NEXT(a_done_pulse, done_o, !done_o)

  // error result has a zero denominator, no whole flag and a zero whole value
  `FR_ASSERT_NOW(a_error_clean, done_o && result_o.error,
    result_o.reduced_denominator == '0 && !result_o.is_whole && result_o.whole_value == '0)

  // a good result never has a zero denominator
  `FR_ASSERT_NOW(a_den_nonzero, done_o && !result_o.error, result_o.reduced_denominator != '0)

endmodule

bind fraction_reducer fr_checker u_fr_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);

>>> tb/tb_fraction_reducer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction reducer testbench
// drives signed fractions through the start/busy command port, predicts the
// lowest-terms result of each transfer and checks every done_o strobe against it
// ----------------------------------------------------------------------------
module tb_fraction_reducer;

  localparam int W          = fr_pkg::DataWidth;
  localparam int RandItems  = 1730;
  localparam int DrainWait  = 250;
  localparam int StallLimit = 2000;

  class reduction_scoreboard;
    fr_pkg::out_t expected_q[$];
    int           mismatches = 0;

    function fr_pkg::out_t reduce(fr_pkg::in_t f);
      logic [W-1:0] n_mag, d_mag, a, b, t, rn, rd;
      logic         sn, sd;
      fr_pkg::out_t r;
      r  = '0;
      sn = f.numerator[W-1];
      sd = f.denominator[W-1];
      n_mag = sn ? W'(0) - W'(f.numerator) : W'(f.numerator);
      d_mag = sd ? W'(0) - W'(f.denominator) : W'(f.denominator);
      if (d_mag == 0) begin
        r.error = 1'b1;
        return r;
      end
      if (n_mag == 0) begin
        r.reduced_denominator = 1;
        r.is_whole = 1'b1;
        return r;
      end
      a = n_mag;
      b = d_mag;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      rn = n_mag / a;
      rd = d_mag / a;
      r.reduced_numerator   = sn ? W'(0) - rn : rn;
      r.reduced_denominator = sd ? W'(0) - rd : rd;
      if (rd == 1) begin
        r.is_whole    = 1'b1;
        r.whole_value = (sn ^ sd) ? W'(0) - rn : rn;
      end
      return r;
    endfunction

    function void note_operands(fr_pkg::in_t f);
      expected_q.push_back(reduce(f));
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [W-1:0] got, logic [W-1:0] exp);
      if (got !== exp)
        report($sformatf("%s got %h expected %h", name, got, exp));
    endtask

    task check_result(fr_pkg::out_t r);
      fr_pkg::out_t e;
      if (expected_q.size() == 0) begin
        report("result strobe with no transfer pending");
        return;
      end
      e = expected_q.pop_front();
      compare_field("reduced_numerator", r.reduced_numerator, e.reduced_numerator);
      compare_field("reduced_denominator", r.reduced_denominator, e.reduced_denominator);
      compare_field("is_whole", W'(r.is_whole), W'(e.is_whole));
      compare_field("whole_value", r.whole_value, e.whole_value);
      compare_field("error", W'(r.error), W'(e.error));
    endtask
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         start;
  fr_pkg::in_t  operands_i;
  logic         busy;
  logic         done_o;
  fr_pkg::out_t result_o;

  reduction_scoreboard sb;
  int                  stall_cycles = 0;

  fraction_reducer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .operands_i (operands_i),
    .busy       (busy),
    .done_o     (done_o),
    .result_o   (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // results first, so a strobe at the edge of a new transfer pairs with the old one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(result_o);
      if (start && !busy) sb.note_operands(operands_i);
      if (done_o || (start && !busy)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= StallLimit) begin
        $display("** fraction_reducer: FAILED **");
        $finish;
      end
    end
  end

  function automatic logic [W-1:0] rand_sized();
    logic [W-1:0] v;
    v = W'($urandom) >> $urandom_range(0, W - 1);
    return $urandom_range(1) ? W'(0) - v : v;
  endfunction

  task automatic send_operands(input fr_pkg::in_t item, input bit steady);
    if (!steady && $urandom_range(99) < 31) begin
      start      <= 1'b0;
      operands_i <= {W'($urandom), W'($urandom)};
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start      <= 1'b1;
    operands_i <= item;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    logic [W-1:0] n, d, g;
    fr_pkg::in_t  item;
    sb           = new();
    rst_ni       = 1'b0;
    start        = 1'b0;
    operands_i   = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_operands('{32'sd0, 32'sd5}, 1'b0);
    send_operands('{32'sd0, -32'sd5}, 1'b0);
    send_operands('{32'sd7, 32'sd0}, 1'b0);
    send_operands('{32'sd0, 32'sd0}, 1'b0);
    send_operands('{32'sh8000_0000, 32'sd0}, 1'b0);
    send_operands('{32'sd1, 32'sd1}, 1'b0);
    send_operands('{-32'sd1, 32'sd1}, 1'b0);
    send_operands('{32'sd6, 32'sd4}, 1'b0);
    send_operands('{-32'sd6, 32'sd4}, 1'b0);
    send_operands('{32'sd6, -32'sd4}, 1'b0);
    send_operands('{-32'sd6, -32'sd4}, 1'b0);
    send_operands('{32'sd12, 32'sd3}, 1'b0);
    send_operands('{32'sd12, -32'sd3}, 1'b0);
    send_operands('{32'sd7919, 32'sd104729}, 1'b0);
    send_operands('{32'sh7fff_ffff, 32'sh7fff_ffff}, 1'b0);
    send_operands('{32'sh7fff_ffff, 32'sh8000_0001}, 1'b0);
    send_operands('{32'sh8000_0000, -32'sd1}, 1'b0);
    send_operands('{32'sh8000_0000, 32'sh8000_0000}, 1'b0);
    send_operands('{32'sh8000_0000, 32'sh7fff_ffff}, 1'b0);
    send_operands('{32'sd1, 32'sh8000_0000}, 1'b0);
    send_operands('{32'sh4000_0000, 32'sh2000_0000}, 1'b0);
    send_operands('{32'sh7fff_fffe, 32'sd2}, 1'b0);
    send_operands('{32'sh8000_0000, 32'sd6}, 1'b0);
    send_operands('{-32'sd1, 32'sh7fff_ffff}, 1'b0);

    for (int i = 0; i < RandItems; i++) begin
      case ($urandom_range(99)) inside
        [0:24]: begin
          n = W'($urandom);
          d = W'($urandom);
        end
        [25:49]: begin
          g = W'($urandom_range(1, 1 << $urandom_range(0, 15)));
          n = g * W'($urandom_range(0, 65535));
          d = g * W'($urandom_range(1, 65535));
          if ($urandom_range(1)) n = W'(0) - n;
          if ($urandom_range(1)) d = W'(0) - d;
        end
        [50:64]: begin
          d = rand_sized();
          n = d * rand_sized();
        end
        [65:74]: begin
          n = (W'($urandom) | W'(1)) << $urandom_range(0, W - 1);
          d = (W'($urandom) | W'(1)) << $urandom_range(0, W - 1);
        end
        [75:81]: begin
          n = '0;
          d = rand_sized();
        end
        [82:85]: begin
          n = rand_sized();
          d = '0;
        end
        default: begin
          case ($urandom_range(3))
            0: n = {1'b1, {(W - 1){1'b0}}};
            1: n = {1'b0, {(W - 1){1'b1}}};
            2: n = W'(0) - W'(1);
            default: n = rand_sized();
          endcase
          case ($urandom_range(3))
            0: d = {1'b1, {(W - 1){1'b0}}};
            1: d = {1'b0, {(W - 1){1'b1}}};
            2: d = W'(0) - W'(1);
            default: d = rand_sized();
          endcase
        end
      endcase
      item.numerator   = n;
      item.denominator = d;
      // a long steady run with back-to-back transfers
      send_operands(item, i >= 700 && i < 1000);
    end
    start <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("** fraction_reducer: PASSED **");
    end else begin
      $display("** fraction_reducer: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/fr_pkg.sv
src/fr_seq.sv
src/fraction_reducer.sv
src/fr_checker.sv
tb/tb_fraction_reducer.sv
